// File: hw/rtl/xxh32_pkg.sv
// Shared constants, types and helper functions of the xxHash32 stream hasher.
package xxh32_pkg;

   localparam logic [31:0] PRIME_1 = 32'd2654435761;
   localparam logic [31:0] PRIME_2 = 32'd2246822519;
   localparam logic [31:0] PRIME_3 = 32'd3266489917;
   localparam logic [31:0] PRIME_4 = 32'd668265263;
   localparam logic [31:0] PRIME_5 = 32'd374761393;

   // Codes that select the constant factor of the shared multiplier.
   localparam logic [2:0] SEL_PRIME_1 = 3'd0;
   localparam logic [2:0] SEL_PRIME_2 = 3'd1;
   localparam logic [2:0] SEL_PRIME_3 = 3'd2;
   localparam logic [2:0] SEL_PRIME_4 = 3'd3;
   localparam logic [2:0] SEL_PRIME_5 = 3'd4;

   typedef struct packed {
      logic [31:0] operand;
      logic [2:0]  prime_sel;
   } mul_req_type;

   function automatic logic [31:0] prime_value(input logic [2:0] sel);
      logic [31:0] value;
      unique case (sel)
         SEL_PRIME_1: value = PRIME_1;
         SEL_PRIME_2: value = PRIME_2;
         SEL_PRIME_3: value = PRIME_3;
         SEL_PRIME_4: value = PRIME_4;
         SEL_PRIME_5: value = PRIME_5;
         default:     value = PRIME_1;
      endcase
      return value;
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
      return (v << s) | (v >> (32 - s));
   endfunction

endpackage

// File: hw/rtl/xxh32_mul.sv
// Shared registered multiplier: operand times a selected prime, low 32 bits.
module xxh32_mul (
   input  logic                    clock,
   input  xxh32_pkg::mul_req_type  req,
   output logic [31:0]             product
);

   logic [31:0] product_ff;
   logic [31:0] product_in;
   logic [31:0] factor;

   assign factor     = xxh32_pkg::prime_value(req.prime_sel);
   assign product_in = 32'(req.operand * factor);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// File: hw/rtl/xxhash32_stream_hasher.sv
// Top level of the xxHash32 stream hasher: sequencer, lane state and result register.
//
// The block hashes a message that arrives as little-endian 32-bit words and returns one
// xxHash32 digest per message on the response channel. Every transaction other than the
// last is taken as four bytes; the last carries 0 to 4 bytes as given by its byte count
// (values above four are treated as four). The user must write the seed through the csr
// port only while the block is idle; the block does not enforce this. The seed is used
// when the lanes start or, for a short message, at the end. Timing is set by the single
// registered 32-bit multiplier that all rounds share: each round is a multiply by a
// prime, an add and rotate, and a second multiply. A word that only goes into the pending
// buffer needs no round. A word that completes a 16-byte stripe starts the four lane
// rounds, which run one after another. The last transaction runs those rounds if it
// completes a stripe, then the lane merge, a round per pending word (up to three), a
// round per tail byte (up to three) and the avalanche. The finished digest sits in an
// output register, and the next message may start while it waits to be taken.
module xxhash32_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] data_word, [34:32] byte_count, rest zero
   input  logic        req_tlast,   // is_last
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] hash_value
   // Configuration port for the seed.
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_LANE_A = 4'd1;
   localparam logic [3:0] ST_LANE_B = 4'd2;
   localparam logic [3:0] ST_LANE_C = 4'd3;
   localparam logic [3:0] ST_MERGE  = 4'd4;
   localparam logic [3:0] ST_PEND_A = 4'd5;
   localparam logic [3:0] ST_PEND_B = 4'd6;
   localparam logic [3:0] ST_PEND_C = 4'd7;
   localparam logic [3:0] ST_BYTE_A = 4'd8;
   localparam logic [3:0] ST_BYTE_B = 4'd9;
   localparam logic [3:0] ST_BYTE_C = 4'd10;
   localparam logic [3:0] ST_AV_1   = 4'd11;
   localparam logic [3:0] ST_AV_2   = 4'd12;
   localparam logic [3:0] ST_AV_3   = 4'd13;

   // Control state.
   logic [3:0]  state_ff, state_in;
   logic [1:0]  idx_ff, idx_in;
   logic [1:0]  pcnt_ff, pcnt_in;
   logic [31:0] len_ff, len_in;
   logic        seen_ff, seen_in;
   logic [31:0] seed_ff, seed_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Payload state.
   logic [31:0] pend_ff [3];
   logic [31:0] pend_in [3];
   logic [31:0] lane_ff [4];
   logic [31:0] lane_in [4];
   logic [31:0] word_ff, word_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;
   logic [31:0] h_ff, h_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   // Request fields.
   logic [31:0] req_word;
   logic [2:0]  req_count;
   logic [2:0]  sat_count;
   logic        req_accept;
   logic        out_free;

   // Shared multiplier.
   xxh32_pkg::mul_req_type mul_req;
   logic [31:0]            product;

   // Working values.
   logic [31:0] lane_word;
   logic [31:0] round_sum;
   logic [31:0] merge_value;
   logic [7:0]  tail_byte;

   assign req_word   = req_tdata[31:0];
   assign req_count  = req_tdata[34:32];
   assign sat_count  = (req_count > 3'd4) ? 3'd4 : req_count;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   xxh32_mul u_mul (
      .clock   (clock),
      .req     (mul_req),
      .product (product)
   );

   // The fourth word of a stripe is the word held from the accepting transaction.
   assign lane_word   = (idx_ff == 2'd3) ? word_ff : pend_ff[idx_ff];
   assign tail_byte   = word_ff[{idx_ff, 3'b000} +: 8];
   assign merge_value = xxh32_pkg::rotl(lane_ff[0], 1) + xxh32_pkg::rotl(lane_ff[1], 7)
                      + xxh32_pkg::rotl(lane_ff[2], 12) + xxh32_pkg::rotl(lane_ff[3], 18);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pcnt_in      = pcnt_ff;
      len_in       = len_ff;
      seen_in      = seen_ff;
      seed_in      = csr_write_enable ? csr_write_data : seed_ff;
      pend_in      = pend_ff;
      lane_in      = lane_ff;
      word_in      = word_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      h_in         = h_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mul_req      = '{operand: 32'd0, prime_sel: xxh32_pkg::SEL_PRIME_1};
      round_sum    = 32'd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               word_in = req_word;
               last_in = req_tlast;
               idx_in  = 2'd0;
               len_in  = len_ff + (req_tlast ? 32'(sat_count) : 32'd4);
               // A full last word is pushed like any other, leaving no tail bytes.
               cnt_in  = (req_tlast && sat_count != 3'd4) ? sat_count[1:0] : 2'd0;
               if (!req_tlast || sat_count == 3'd4) begin
                  if (pcnt_ff != 2'd3) begin
                     pend_in[pcnt_ff] = req_word;
                     pcnt_in          = pcnt_ff + 2'd1;
                     state_in         = req_tlast ? ST_MERGE : ST_IDLE;
                  end else begin
                     // Lanes start from the seed when the first stripe goes in.
                     if (!seen_ff) begin
                        lane_in[0] = seed_ff + xxh32_pkg::PRIME_1 + xxh32_pkg::PRIME_2;
                        lane_in[1] = seed_ff + xxh32_pkg::PRIME_2;
                        lane_in[2] = seed_ff;
                        lane_in[3] = seed_ff - xxh32_pkg::PRIME_1;
                     end
                     seen_in  = 1'b1;
                     pcnt_in  = 2'd0;
                     state_in = ST_LANE_A;
                  end
               end else begin
                  state_in = ST_MERGE;
               end
            end
         end
         ST_LANE_A: begin
            mul_req  = '{operand: lane_word, prime_sel: xxh32_pkg::SEL_PRIME_2};
            state_in = ST_LANE_B;
         end
         ST_LANE_B: begin
            round_sum = lane_ff[idx_ff] + product;
            mul_req   = '{operand: xxh32_pkg::rotl(round_sum, 13),
                          prime_sel: xxh32_pkg::SEL_PRIME_1};
            state_in  = ST_LANE_C;
         end
         ST_LANE_C: begin
            lane_in[idx_ff] = product;
            if (idx_ff == 2'd3) begin
               idx_in   = 2'd0;
               state_in = last_ff ? ST_MERGE : ST_IDLE;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_LANE_A;
            end
         end
         ST_MERGE: begin
            h_in   = (seen_ff ? merge_value : seed_ff + xxh32_pkg::PRIME_5) + len_ff;
            idx_in = 2'd0;
            priority if (pcnt_ff != 2'd0) begin
               state_in = ST_PEND_A;
            end else if (cnt_ff != 2'd0) begin
               state_in = ST_BYTE_A;
            end else begin
               state_in = ST_AV_1;
            end
         end
         ST_PEND_A: begin
            mul_req  = '{operand: pend_ff[idx_ff], prime_sel: xxh32_pkg::SEL_PRIME_3};
            state_in = ST_PEND_B;
         end
         ST_PEND_B: begin
            round_sum = h_ff + product;
            mul_req   = '{operand: xxh32_pkg::rotl(round_sum, 17),
                          prime_sel: xxh32_pkg::SEL_PRIME_4};
            state_in  = ST_PEND_C;
         end
         ST_PEND_C: begin
            h_in = product;
            priority if (idx_ff + 2'd1 != pcnt_ff) begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_PEND_A;
            end else if (cnt_ff != 2'd0) begin
               idx_in   = 2'd0;
               state_in = ST_BYTE_A;
            end else begin
               state_in = ST_AV_1;
            end
         end
         ST_BYTE_A: begin
            mul_req  = '{operand: 32'(tail_byte), prime_sel: xxh32_pkg::SEL_PRIME_5};
            state_in = ST_BYTE_B;
         end
         ST_BYTE_B: begin
            round_sum = h_ff + product;
            mul_req   = '{operand: xxh32_pkg::rotl(round_sum, 11),
                          prime_sel: xxh32_pkg::SEL_PRIME_1};
            state_in  = ST_BYTE_C;
         end
         ST_BYTE_C: begin
            h_in = product;
            if (idx_ff + 2'd1 != cnt_ff) begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_BYTE_A;
            end else begin
               state_in = ST_AV_1;
            end
         end
         ST_AV_1: begin
            mul_req  = '{operand: h_ff ^ (h_ff >> 15), prime_sel: xxh32_pkg::SEL_PRIME_2};
            state_in = ST_AV_2;
         end
         ST_AV_2: begin
            // The operand of the last multiply is kept so that it can be repeated.
            h_in     = product ^ (product >> 13);
            mul_req  = '{operand: product ^ (product >> 13),
                         prime_sel: xxh32_pkg::SEL_PRIME_3};
            state_in = ST_AV_3;
         end
         ST_AV_3: begin
            // The product register holds its value until the result slot is free.
            mul_req = '{operand: h_ff, prime_sel: xxh32_pkg::SEL_PRIME_3};
            if (out_free) begin
               rsp_data_in  = product ^ (product >> 16);
               rsp_valid_in = 1'b1;
               pcnt_in      = 2'd0;
               len_in       = 32'd0;
               seen_in      = 1'b0;
               idx_in       = 2'd0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // In the wait on a full result slot the multiplier repeats the last avalanche
   // multiply, so its product is the same in every cycle of the wait.

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= 2'd0;
         pcnt_ff      <= 2'd0;
         len_ff       <= 32'd0;
         seen_ff      <= 1'b0;
         seed_ff      <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pcnt_ff      <= pcnt_in;
         len_ff       <= len_in;
         seen_ff      <= seen_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      lane_ff     <= lane_in;
      word_ff     <= word_in;
      cnt_ff      <= cnt_in;
      last_ff     <= last_in;
      h_ff        <= h_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Lane rounds only run once the lanes have been started.
   a_lanes_started: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LANE_A || state_ff == ST_LANE_B || state_ff == ST_LANE_C) |-> seen_ff)
      else $error("lane round without started lanes");

   // Pending words are read only below the fill count.
   a_pend_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PEND_A) |-> (idx_ff < pcnt_ff))
      else $error("pending word read beyond fill count");

   // Delivering a digest leaves the message state cleared.
   a_message_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AV_3 && out_free) |=>
         (pcnt_ff == 2'd0 && len_ff == 32'd0 && !seen_ff && state_ff == ST_IDLE))
      else $error("message state not cleared after digest");

   // A new result appears only from the last avalanche step.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp_tready) ##1 rsp_valid_ff |-> ($past(state_ff) == ST_AV_3))
      else $error("result produced outside the avalanche step");

endmodule

// File: bench/xxhash32_stream_hasher_checker.sv
// Checker for the xxHash32 stream hasher: watches both channels, predicts digests and compares.
`timescale 1ns / 100ps

module xxhash32_stream_hasher_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] data_word, [34:32] byte_count, rest zero
   input  logic        req_tlast,   // is_last
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] hash_value
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   output int unsigned mismatch_count,
   output int unsigned digests_checked,
   output int unsigned digests_waiting
);

   logic [31:0] seed_q;
   logic [31:0] lane [4];
   logic [31:0] held_word [3];
   logic [1:0]  held_count;
   logic [31:0] msg_bytes;
   logic        stripe_done;
   logic [31:0] digest_fifo [$];

   function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic logic [31:0] lane_round(input logic [31:0] acc, input logic [31:0] w);
      logic [31:0] sum;
      sum = acc + w * xxh32_pkg::PRIME_2;
      return rol32(sum, 13) * xxh32_pkg::PRIME_1;
   endfunction

   task automatic clear_message();
      held_count  = 2'd0;
      msg_bytes   = 32'd0;
      stripe_done = 1'b0;
   endtask

   // One full word goes either into the holding buffer or completes a stripe.
   task automatic absorb_word(input logic [31:0] w);
      if (held_count < 2'd3) begin
         held_word[held_count] = w;
         held_count = held_count + 2'd1;
      end else begin
         if (!stripe_done) begin
            lane[0] = seed_q + xxh32_pkg::PRIME_1 + xxh32_pkg::PRIME_2;
            lane[1] = seed_q + xxh32_pkg::PRIME_2;
            lane[2] = seed_q;
            lane[3] = seed_q - xxh32_pkg::PRIME_1;
            stripe_done = 1'b1;
         end
         lane[0] = lane_round(lane[0], held_word[0]);
         lane[1] = lane_round(lane[1], held_word[1]);
         lane[2] = lane_round(lane[2], held_word[2]);
         lane[3] = lane_round(lane[3], w);
         held_count = 2'd0;
      end
   endtask

   task automatic take_item(input logic [31:0] word, input logic [2:0] count, input logic last);
      logic [31:0] h;
      int unsigned tail;
      int unsigned i;
      if (!last) begin
         msg_bytes = msg_bytes + 32'd4;
         absorb_word(word);
      end else begin
         tail = (count > 3'd4) ? 4 : count;
         msg_bytes = msg_bytes + tail;
         if (tail == 4) begin
            absorb_word(word);
            tail = 0;
         end
         if (stripe_done)
            h = rol32(lane[0], 1) + rol32(lane[1], 7) + rol32(lane[2], 12) + rol32(lane[3], 18);
         else
            h = seed_q + xxh32_pkg::PRIME_5;
         h = h + msg_bytes;
         for (i = 0; i < held_count; i++) begin
            h = h + held_word[i] * xxh32_pkg::PRIME_3;
            h = rol32(h, 17) * xxh32_pkg::PRIME_4;
         end
         for (i = 0; i < tail; i++) begin
            h = h + {24'd0, word[8*i +: 8]} * xxh32_pkg::PRIME_5;
            h = rol32(h, 11) * xxh32_pkg::PRIME_1;
         end
         h = h ^ (h >> 15);
         h = h * xxh32_pkg::PRIME_2;
         h = h ^ (h >> 13);
         h = h * xxh32_pkg::PRIME_3;
         h = h ^ (h >> 16);
         digest_fifo.push_back(h);
         clear_message();
      end
   endtask

   // The response is checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         seed_q = 32'd0;
         clear_message();
         digest_fifo.delete();
         mismatch_count  = 0;
         digests_checked = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (digest_fifo.size() == 0) begin
               $error("rsp transaction with no digest expected: hash_value %08h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = digest_fifo.pop_front();
               digests_checked++;
               if (rsp_tdata !== want) begin
                  $error("hash_value mismatch: expected %08h, actual %08h", want, rsp_tdata);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            take_item(req_tdata[31:0], req_tdata[34:32], req_tlast);
         if (csr_write_enable)
            seed_q = csr_write_data;
      end
      digests_waiting <= digest_fifo.size();
   end

endmodule

// File: bench/xxhash32_stream_hasher_test.sv
// Top level of the xxHash32 stream hasher test: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 100ps

module xxhash32_stream_hasher_test;

   // Wait before a seed write and at the end; it leaves margin over the slowest last transaction.
   localparam int unsigned LATENCY_CYCLES   = 40;
   localparam int unsigned LONG_HOLD_CYCLES = 600;
   localparam int unsigned PHASE_ITEMS      = 550;
   localparam int unsigned DRAIN_LIMIT      = 5000;
   // Several times the slowest legal run.
   localparam int unsigned TIMEOUT_NS       = 4_800_000;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_tvalid       = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata        = '0;   // [31:0] data_word, [34:32] byte_count, rest zero
   logic        req_tlast        = 1'b0; // is_last
   logic        rsp_tvalid;
   logic        rsp_tready       = 1'b0;
   logic [31:0] rsp_tdata;               // [31:0] hash_value
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data   = '0;

   int unsigned mismatch_count;
   int unsigned digests_checked;
   int unsigned digests_waiting;

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   // The stimulus asks for a long receiver hold-off by bumping holds_asked; the
   // receiver process serves each request once and counts the cycles itself.
   int unsigned holds_asked    = 0;
   int unsigned holds_served   = 0;
   int unsigned hold_left      = 0;

   int unsigned items_sent     = 0;
   int unsigned messages_sent  = 0;
   int unsigned seeds_written  = 0;

   xxhash32_stream_hasher i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   xxhash32_stream_hasher_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .digests_checked  (digests_checked),
      .digests_waiting  (digests_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: random stalls, or a long hold-off when one has been requested.
   // While it holds off, a finished digest waits in the block's output register, the next
   // one holds the block in its last avalanche step, and the request channel stalls too.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_tready   <= 1'b0;
         hold_left    <= LONG_HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offers one request transaction, after a random number of idle cycles, and
   // returns at the edge at which it was accepted. A valid that stays high for
   // the next transaction is never lowered in the same time step.
   task automatic send_item(input logic [31:0] word, input logic [2:0] count, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, count, word};
      req_tlast  <= last;
      do
         @(posedge clock);
      while (!req_tready);
      items_sent++;
      if (last)
         messages_sent++;
   endtask

   // Full words carry a random byte count, which the block must ignore.
   task automatic send_message(input int unsigned full_words, input logic [2:0] tail_count);
      int unsigned i;
      for (i = 0; i < full_words; i++)
         send_item($urandom, 3'($urandom_range(7)), 1'b0);
      send_item($urandom, tail_count, 1'b1);
   endtask

   // Lowers valid and waits until every predicted digest has been taken. The
   // first edge also lets the checker's count include the last transaction.
   task automatic drain_results();
      int unsigned waited;
      waited = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (digests_waiting != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // Seed writes happen only with the block idle, between whole messages.
   task automatic write_seed(input logic [31:0] value);
      drain_results();
      repeat (LATENCY_CYCLES) @(posedge clock);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      seeds_written++;
   endtask

   // Random phase: mostly short messages, some medium and a few long ones, so
   // that lane rounds, the holding buffer and the tail fold all see plenty of
   // traffic. Now and then the sender pauses until all digests are back.
   task automatic random_phase(input int unsigned item_budget);
      int unsigned start_items;
      int unsigned pick;
      int unsigned words;
      start_items = items_sent;
      while (items_sent - start_items < item_budget) begin
         pick = $urandom_range(99);
         if (pick < 70)
            words = $urandom_range(12);
         else if (pick < 95)
            words = $urandom_range(40, 13);
         else
            words = $urandom_range(80, 41);
         send_message(words, 3'($urandom_range(7)));
         if ($urandom_range(24) == 0)
            drain_results();
      end
   endtask

   initial begin
      int unsigned n;
      int unsigned leftover;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with seed zero: the empty message, every tail byte count
      // including the saturating ones, a full last word that completes a stripe,
      // a stripe followed by an empty tail, and a stripe with three held words
      // and three tail bytes, which is the longest finish the block has.
      write_seed(32'h0000_0000);
      send_item(32'h0000_0000, 3'd0, 1'b1);
      for (n = 1; n <= 7; n++)
         send_item((n % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, 3'(n), 1'b1);
      for (n = 0; n < 3; n++)
         send_item(32'hFFFF_FFFF, 3'd7, 1'b0);
      send_item(32'hFFFF_FFFF, 3'd4, 1'b1);
      for (n = 0; n < 4; n++)
         send_item(32'h0000_0000, 3'd0, 1'b0);
      send_item(32'h1234_5678, 3'd0, 1'b1);
      for (n = 0; n < 7; n++)
         send_item($urandom, 3'($urandom_range(7)), 1'b0);
      send_item(32'hFFFF_FFFF, 3'd3, 1'b1);

      // First phase: the sender idles a little, the receiver often.
      write_seed(32'hFFFF_FFFF);
      send_idle_pct  = 10;
      recv_stall_pct <= 46;
      random_phase(PHASE_ITEMS);

      // Second phase: the other way round.
      write_seed($urandom);
      send_idle_pct  = 46;
      recv_stall_pct <= 10;
      random_phase(PHASE_ITEMS);

      // Third phase: nobody idles. It opens with a long receiver hold-off while
      // the sender keeps offering short messages, so the block backs up and
      // stalls its input.
      write_seed($urandom);
      send_idle_pct  = 0;
      recv_stall_pct <= 0;
      holds_asked <= holds_asked + 1;
      for (n = 0; n < 12; n++)
         send_message($urandom_range(2), 3'($urandom_range(7)));
      random_phase(PHASE_ITEMS);

      drain_results();
      repeat (LATENCY_CYCLES) @(posedge clock);

      leftover = digests_waiting;
      if (leftover != 0)
         $error("%0d predicted digests never arrived on the rsp channel", leftover);

      $display("Summary: %0d request transactions in %0d messages, %0d digests checked.",
               items_sent, messages_sent, digests_checked);
      $display("Summary: %0d seed settings, three idling mixes and one long receiver hold-off.",
               seeds_written);

      if (mismatch_count == 0 && leftover == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $error("run did not finish in time");
      $display("end of test: mismatches");
      $finish;
   end

endmodule
